>>> hdl/ang_pkg.sv
// ang_pkg: shared constants, register map and sequencer states of the noise gate.
// No dependencies; imported by audio_noise_gate.
package ang_pkg;

   // frame layout and parameter defaults
   localparam int NUM_CH          = 8;
   localparam int IDX_W           = $clog2(NUM_CH);
   localparam int CHANNELS_DEF    = 8;
   localparam int SAMPLE_BITS_DEF = 24;

   // register and field widths
   localparam int MASK_W  = 8;
   localparam int COEF_W  = 24;
   localparam int GAIN_W  = 25;
   localparam int LEVEL_W = 17;

   // level detector
   localparam int NORM_W    = 31;   // mantissa held as Q1.30
   localparam int NORM_STEP = 8;    // coarse left shift while the top bits are clear
   localparam int P_W       = 6;    // top-bit index, up to SAMPLE_BITS+2
   localparam int FRAC_W    = 16;   // log2 fraction bits, one per squaring
   localparam int EXP_W     = 8;
   localparam int LOG_W     = EXP_W + FRAC_W;
   localparam int CNT_W     = 4;    // counts channels (0..8) and squarings (0..15)

   // shared multiplier
   localparam int MUL_W  = 32;
   localparam int PROD_W = 2 * MUL_W;
   localparam int RND_SH = 24;

   localparam logic [MUL_W-1:0]          DB_PER_LOG2 = MUL_W'(394566);  // 6.0206 in Q16
   localparam logic signed [LEVEL_W-1:0] ZERO_LEVEL  = -LEVEL_W'(46080); // -180 dB

   // configuration port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_MONITOR_MASK = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PROCESS_MASK = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_ATTACK_COEF  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_RELEASE_COEF = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_THRESHOLD_DB = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_CLOSED_GAIN  = 3'd5;

   localparam logic [MASK_W-1:0]         MONITOR_MASK_RST = 8'hff;
   localparam logic [MASK_W-1:0]         PROCESS_MASK_RST = 8'hff;
   localparam logic signed [LEVEL_W-1:0] THRESHOLD_RST    = -LEVEL_W'(15360); // -60 dB

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SUM,
      ST_MAG,
      ST_NORM,
      ST_LOG,
      ST_DB_MUL,
      ST_DB_RND,
      ST_ENV_SEL,
      ST_ENV_MA,
      ST_ENV_MB,
      ST_ENV_RND,
      ST_ENV_CMP,
      ST_GAIN,
      ST_DONE
   } state_type;

endpackage

>>> hdl/audio_noise_gate.sv
// audio_noise_gate: attack/release noise gate on a multichannel frame; uses ang_pkg.
// One shared signed 32x32 multiplier under a small sequencer, one request in flight.
// Steps: channel sum, magnitude, normalize, log2 squarings, dB/envelope, gain (gate shut
// only), output load; an empty monitor mask skips to the load, a zero sum skips normalize,
// log2 and dB. A request is taken once the last result is loaded; a stall delays the load.
// Sync active-high reset clears sequencer, output valid, envelope (0 dB); CSRs to defaults.
module audio_noise_gate
   import ang_pkg::*;
#(
   parameter int CHANNELS    = CHANNELS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [SAMPLE_BITS-1:0] req_in_0,
   input  logic signed [SAMPLE_BITS-1:0] req_in_1,
   input  logic signed [SAMPLE_BITS-1:0] req_in_2,
   input  logic signed [SAMPLE_BITS-1:0] req_in_3,
   input  logic signed [SAMPLE_BITS-1:0] req_in_4,
   input  logic signed [SAMPLE_BITS-1:0] req_in_5,
   input  logic signed [SAMPLE_BITS-1:0] req_in_6,
   input  logic signed [SAMPLE_BITS-1:0] req_in_7,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_0,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_1,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_2,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_3,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_4,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_5,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_6,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_7,
   output logic                          rsp_gate_open,
   // configuration port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [CSR_DATA_W-1:0]         csr_pwdata,
   output logic [CSR_DATA_W-1:0]         csr_prdata,
   output logic                          csr_pready
);

   // exact sum of eight samples needs three guard bits
   localparam int SUM_W = SAMPLE_BITS + 3;
   localparam int X_W   = (SUM_W > 32) ? SUM_W : 32;
   localparam int R_W   = PROD_W - RND_SH;

   // channels at or above CHANNELS ignore both masks
   localparam logic [NUM_CH-1:0] CH_EN = NUM_CH'((1 << CHANNELS) - 1);

   localparam logic signed [R_W-1:0] SAT_MAX = R_W'((longint'(1) << (SAMPLE_BITS-1)) - 1);
   localparam logic signed [R_W-1:0] SAT_MIN = R_W'(-(longint'(1) << (SAMPLE_BITS-1)));
   localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) << (RND_SH - 1);
   localparam logic [COEF_W:0] UNITY = (COEF_W+1)'(1) << COEF_W;

   // ---------------------------------------------------------------------
   // CSRs
   // ---------------------------------------------------------------------
   logic [MASK_W-1:0]         monitor_mask_ff;
   logic [MASK_W-1:0]         process_mask_ff;
   logic [COEF_W-1:0]         attack_coef_ff;
   logic [COEF_W-1:0]         release_coef_ff;
   logic signed [LEVEL_W-1:0] threshold_ff;
   logic [GAIN_W-1:0]         closed_gain_ff;

   logic [REG_IDX_W-1:0] csr_idx;
   logic                 csr_wr;

   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         monitor_mask_ff <= MONITOR_MASK_RST;
         process_mask_ff <= PROCESS_MASK_RST;
         attack_coef_ff  <= '0;
         release_coef_ff <= '0;
         threshold_ff    <= THRESHOLD_RST;
         closed_gain_ff  <= '0;
      end else if (csr_wr) begin
         unique case (csr_idx)
            REG_MONITOR_MASK: monitor_mask_ff <= csr_pwdata[MASK_W-1:0];
            REG_PROCESS_MASK: process_mask_ff <= csr_pwdata[MASK_W-1:0];
            REG_ATTACK_COEF:  attack_coef_ff  <= csr_pwdata[COEF_W-1:0];
            REG_RELEASE_COEF: release_coef_ff <= csr_pwdata[COEF_W-1:0];
            REG_THRESHOLD_DB: threshold_ff    <= csr_pwdata[LEVEL_W-1:0];
            REG_CLOSED_GAIN:  closed_gain_ff  <= csr_pwdata[GAIN_W-1:0];
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_MONITOR_MASK: csr_prdata = CSR_DATA_W'(monitor_mask_ff);
         REG_PROCESS_MASK: csr_prdata = CSR_DATA_W'(process_mask_ff);
         REG_ATTACK_COEF:  csr_prdata = CSR_DATA_W'(attack_coef_ff);
         REG_RELEASE_COEF: csr_prdata = CSR_DATA_W'(release_coef_ff);
         REG_THRESHOLD_DB: csr_prdata = CSR_DATA_W'(unsigned'(threshold_ff));
         REG_CLOSED_GAIN:  csr_prdata = CSR_DATA_W'(closed_gain_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Datapath storage
   // ---------------------------------------------------------------------
   state_type state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic signed [SAMPLE_BITS-1:0] req_vec     [NUM_CH];
   logic signed [SAMPLE_BITS-1:0] samp_ff     [NUM_CH];  // frame, gated in place
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff [NUM_CH];  // output register
   logic                          rsp_valid_ff;
   logic                          rsp_open_ff;

   logic signed [SUM_W-1:0]   sum_ff;
   logic [X_W-1:0]            x_ff;       // mantissa search, value = x * 2^(p-30)
   logic [P_W-1:0]            p_ff;
   logic [NORM_W-1:0]         xn_ff;      // normalized Q1.30 for squaring
   logic [FRAC_W-1:0]         frac_ff;
   logic signed [LEVEL_W-1:0] level_ff;
   logic signed [LEVEL_W-1:0] env_ff;
   logic [COEF_W-1:0]         coef_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [PROD_W-1:0]  acc_ff;
   logic                      open_ff;
   logic                      gflag_ff;   // channel now in prod_ff gets the gain

   assign req_vec[0] = req_in_0;
   assign req_vec[1] = req_in_1;
   assign req_vec[2] = req_in_2;
   assign req_vec[3] = req_in_3;
   assign req_vec[4] = req_in_4;
   assign req_vec[5] = req_in_5;
   assign req_vec[6] = req_in_6;
   assign req_vec[7] = req_in_7;

   assign rsp_out_0     = rsp_data_ff[0];
   assign rsp_out_1     = rsp_data_ff[1];
   assign rsp_out_2     = rsp_data_ff[2];
   assign rsp_out_3     = rsp_data_ff[3];
   assign rsp_out_4     = rsp_data_ff[4];
   assign rsp_out_5     = rsp_data_ff[5];
   assign rsp_out_6     = rsp_data_ff[6];
   assign rsp_out_7     = rsp_data_ff[7];
   assign rsp_gate_open = rsp_open_ff;
   assign rsp_valid     = rsp_valid_ff;

   // ---------------------------------------------------------------------
   // Derived values
   // ---------------------------------------------------------------------
   logic [IDX_W-1:0]         idx, prev_idx;
   logic                     monitor_any;
   logic [SUM_W-1:0]         mag;
   logic                     x_hi;
   logic signed [EXP_W-1:0]  lexp;
   logic signed [LOG_W-1:0]  log_val;
   logic [COEF_W:0]          coef_c;
   logic [NORM_W:0]          sq;
   logic signed [PROD_W-1:0] db_sum, env_sum, gain_sum;
   logic signed [R_W-1:0]    gain_r;
   logic signed [SAMPLE_BITS-1:0] gain_sat;
   logic                     out_free;

   assign idx         = cnt_ff[IDX_W-1:0];
   assign prev_idx    = IDX_W'(cnt_ff - CNT_W'(1));
   assign monitor_any = |(monitor_mask_ff & CH_EN);
   assign mag         = sum_ff[SUM_W-1] ? unsigned'(-sum_ff) : unsigned'(sum_ff);
   assign x_hi        = |x_ff[X_W-1:NORM_W];

   // log2 in Q.16: integer part p-(SAMPLE_BITS-1), fraction from the squarings
   assign lexp    = signed'(EXP_W'(p_ff)) - EXP_W'(SAMPLE_BITS - 1);
   assign log_val = {lexp, frac_ff};
   assign coef_c  = UNITY - (COEF_W+1)'(coef_ff);

   // every rounding is half up: add half, arithmetic slice
   assign db_sum   = prod_ff + RND_HALF;
   assign env_sum  = acc_ff + prod_ff + RND_HALF;
   assign gain_sum = prod_ff + RND_HALF;
   assign gain_r   = gain_sum[PROD_W-1:RND_SH];

   always_comb begin
      if (gain_r > SAT_MAX) begin
         gain_sat = SAT_MAX[SAMPLE_BITS-1:0];
      end else if (gain_r < SAT_MIN) begin
         gain_sat = SAT_MIN[SAMPLE_BITS-1:0];
      end else begin
         gain_sat = gain_r[SAMPLE_BITS-1:0];
      end
   end

   // ---------------------------------------------------------------------
   // Shared multiplier: squaring, dB scale, envelope blend, channel gain
   // ---------------------------------------------------------------------
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] mul_p;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         ST_LOG: begin
            mul_a = MUL_W'(xn_ff);
            mul_b = MUL_W'(xn_ff);
         end
         ST_DB_MUL: begin
            mul_a = MUL_W'(log_val);
            mul_b = DB_PER_LOG2;
         end
         ST_ENV_MA: begin
            mul_a = MUL_W'(coef_ff);
            mul_b = MUL_W'(env_ff);
         end
         ST_ENV_MB: begin
            mul_a = MUL_W'(coef_c);
            mul_b = MUL_W'(level_ff);
         end
         ST_GAIN: begin
            mul_a = MUL_W'(samp_ff[idx]);
            mul_b = MUL_W'(closed_gain_ff);
         end
         default: ;
      endcase
   end

   assign mul_p = mul_a * mul_b;
   // square truncated back to Q1.30; bit 31 set means the square reached 2.0
   assign sq    = mul_p[2*NORM_W-1:NORM_W-1];

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SUM;
               cnt_in   = '0;
            end
         end
         ST_SUM: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_CH - 1)) begin
               state_in = ST_MAG;
            end
         end
         ST_MAG: begin
            cnt_in = '0;
            if (!monitor_any) begin
               state_in = ST_DONE;            // bypass, envelope held
            end else if (sum_ff == '0) begin
               state_in = ST_ENV_SEL;         // level pinned at -180 dB
            end else begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (!x_hi && x_ff[NORM_W-1]) begin
               state_in = ST_LOG;
            end
         end
         ST_LOG: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(FRAC_W - 1)) begin
               state_in = ST_DB_MUL;
            end
         end
         ST_DB_MUL:  state_in = ST_DB_RND;
         ST_DB_RND:  state_in = ST_ENV_SEL;
         ST_ENV_SEL: state_in = ST_ENV_MA;
         ST_ENV_MA:  state_in = ST_ENV_MB;
         ST_ENV_MB:  state_in = ST_ENV_RND;
         ST_ENV_RND: state_in = ST_ENV_CMP;
         ST_ENV_CMP: begin
            cnt_in   = '0;
            state_in = (env_ff < threshold_ff) ? ST_GAIN : ST_DONE;
         end
         ST_GAIN: begin
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(NUM_CH)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // envelope and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         env_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_ENV_RND) begin
            env_ff <= env_sum[RND_SH+LEVEL_W-1:RND_SH];
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               samp_ff <= req_vec;
               sum_ff  <= '0;
            end
         end
         ST_SUM: begin
            if (monitor_mask_ff[idx] && CH_EN[idx]) begin
               sum_ff <= sum_ff + SUM_W'(samp_ff[idx]);
            end
         end
         ST_MAG: begin
            x_ff     <= X_W'(mag);
            p_ff     <= P_W'(NORM_W - 1);
            level_ff <= ZERO_LEVEL;
            frac_ff  <= '0;
            open_ff  <= 1'b1;
         end
         ST_NORM: begin
            // right shifts truncate, as one wide shift would
            if (x_hi) begin
               x_ff <= x_ff >> 1;
               p_ff <= p_ff + P_W'(1);
            end else if (!x_ff[NORM_W-1]) begin
               if (x_ff[NORM_W-1 -: NORM_STEP] == '0) begin
                  x_ff <= x_ff << NORM_STEP;
                  p_ff <= p_ff - P_W'(NORM_STEP);
               end else begin
                  x_ff <= x_ff << 1;
                  p_ff <= p_ff - P_W'(1);
               end
            end else begin
               xn_ff <= x_ff[NORM_W-1:0];
            end
         end
         ST_LOG: begin
            frac_ff <= {frac_ff[FRAC_W-2:0], sq[NORM_W]};
            xn_ff   <= sq[NORM_W] ? sq[NORM_W:1] : sq[NORM_W-1:0];
         end
         ST_DB_MUL: prod_ff  <= mul_p;
         ST_DB_RND: level_ff <= db_sum[RND_SH+LEVEL_W-1:RND_SH];
         ST_ENV_SEL: coef_ff <= (level_ff > env_ff) ? attack_coef_ff : release_coef_ff;
         ST_ENV_MA: prod_ff  <= mul_p;
         ST_ENV_MB: begin
            acc_ff  <= prod_ff;
            prod_ff <= mul_p;
         end
         ST_ENV_RND: ;
         ST_ENV_CMP: open_ff <= !(env_ff < threshold_ff);
         ST_GAIN: begin
            // multiply channel cnt while channel cnt-1 is rounded and written back
            prod_ff  <= mul_p;
            gflag_ff <= process_mask_ff[idx] & CH_EN[idx];
            if (cnt_ff != '0 && gflag_ff) begin
               samp_ff[prev_idx] <= gain_sat;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_data_ff <= samp_ff;
               rsp_open_ff <= open_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

>>> hdl/ang_checker.sv
// ang_checker: port-level assertions for audio_noise_gate, bound to the top level.
// No package dependency; sees the top-level ports only.
module ang_checker #(
   parameter int SAMPLE_BITS = 24
) (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic signed [SAMPLE_BITS-1:0] rsp_out_0,
   input logic                          rsp_gate_open
);

   // one request in flight: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a frame is in work");

   // a new result only shows after a busy cycle
   a_result_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without a frame in work");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_0) && $stable(rsp_gate_open))
      else $error("stalled result changed");

   // reset leaves the block idle with no result pending
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("not idle after reset");

endmodule

bind audio_noise_gate ang_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_ang_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_out_0     (rsp_out_0),
   .rsp_gate_open (rsp_gate_open)
);

>>> bench/testbench.sv
// testbench: self-checking bench for audio_noise_gate, the multichannel noise gate.
// Depends on ang_pkg and the audio_noise_gate RTL; predicts each gated frame itself,
// drives random traffic with idles and stalls, and programs the CSRs between phases.
module testbench;
   import ang_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int SB           = SAMPLE_BITS_DEF;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 400;    // long receiver hold-off
   localparam int QUIET_LIMIT  = 3000;   // cycles without any handshake before giving up

   // register index the block does not implement; writes there must be dropped
   localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd6;

   typedef logic [NUM_CH-1:0][SB-1:0] frame_t;

   typedef struct packed {
      logic   open;
      frame_t ch;
   } gate_result_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // request channel
   logic   req_valid = 1'b0;
   logic   req_ready;
   frame_t bus_frame = '0;

   // result channel
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic signed [SB-1:0] rsp_out_0, rsp_out_1, rsp_out_2, rsp_out_3;
   logic signed [SB-1:0] rsp_out_4, rsp_out_5, rsp_out_6, rsp_out_7;
   logic              rsp_gate_open;
   frame_t            rsp_frame;

   // configuration port
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   assign rsp_frame = {rsp_out_7, rsp_out_6, rsp_out_5, rsp_out_4,
                       rsp_out_3, rsp_out_2, rsp_out_1, rsp_out_0};

   // Shadow copy of the CSRs and of the envelope, starting from reset values.
   logic [MASK_W-1:0]         gate_mon_mask  = MONITOR_MASK_RST;
   logic [MASK_W-1:0]         gate_proc_mask = PROCESS_MASK_RST;
   logic [COEF_W-1:0]         gate_attack    = '0;
   logic [COEF_W-1:0]         gate_rel       = '0;
   logic signed [LEVEL_W-1:0] gate_thr       = THRESHOLD_RST;
   logic [GAIN_W-1:0]         gate_gain      = '0;
   logic signed [LEVEL_W-1:0] gate_env       = '0;

   frame_t       frames_to_send[$];
   gate_result_t gated_frames_due[$];

   int          send_idle_pct = 0;
   int          stall_pct     = 0;
   int unsigned n_fail        = 0;

   always #5ns clock = ~clock;

   audio_noise_gate u_top (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_0      (bus_frame[0]),
      .req_in_1      (bus_frame[1]),
      .req_in_2      (bus_frame[2]),
      .req_in_3      (bus_frame[3]),
      .req_in_4      (bus_frame[4]),
      .req_in_5      (bus_frame[5]),
      .req_in_6      (bus_frame[6]),
      .req_in_7      (bus_frame[7]),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_0     (rsp_out_0),
      .rsp_out_1     (rsp_out_1),
      .rsp_out_2     (rsp_out_2),
      .rsp_out_3     (rsp_out_3),
      .rsp_out_4     (rsp_out_4),
      .rsp_out_5     (rsp_out_5),
      .rsp_out_6     (rsp_out_6),
      .rsp_out_7     (rsp_out_7),
      .rsp_gate_open (rsp_gate_open),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   // Level in dB, Q8.8, of a sum magnitude. log2 is built from the top-bit index
   // plus 16 fraction bits from repeated squaring of the Q1.30 mantissa; the dB
   // scale (6.0206 in Q16) is applied with round-half-up.
   function automatic longint level_q8(input longint unsigned mag);
      int                p;
      int                i;
      longint unsigned   x;
      longint            frac;
      longint            lg;
      if (mag == 0) begin
         return longint'(ZERO_LEVEL);
      end
      p = 0;
      while (p < 63 && (mag >> (p + 1)) != 0) p++;
      x = (p <= 30) ? (mag << (30 - p)) : (mag >> (p - 30));
      frac = 0;
      for (i = 0; i < FRAC_W; i++) begin
         x = (x * x) >> 30;
         frac = frac << 1;
         if (x >= (64'd1 << 31)) begin
            frac = frac | 1;
            x = x >> 1;
         end
      end
      lg = (longint'(p) - (SB - 1)) * 65536 + frac;
      return (lg * longint'(DB_PER_LOG2) + 64'sd8388608) >>> RND_SH;
   endfunction

   // Gated frame for one request; advances the shadow envelope as a side effect.
   function automatic gate_result_t gated_frame(input frame_t f);
      gate_result_t r;
      longint       sum;
      longint       lvl;
      longint       c;
      longint       e;
      longint       v;
      logic         any;
      logic         open;
      int           i;
      sum  = 0;
      any  = 1'b0;
      open = 1'b1;
      for (i = 0; i < NUM_CH; i++) begin
         if (gate_mon_mask[i]) begin
            sum = sum + longint'($signed(f[i]));
            any = 1'b1;
         end
      end
      // empty monitor mask: envelope held, gate reported open
      if (any) begin
         lvl = level_q8(sum < 0 ? -sum : sum);
         c = (lvl > longint'(gate_env)) ? longint'(gate_attack) : longint'(gate_rel);
         e = (c * longint'(gate_env) + ((64'sd1 <<< 24) - c) * lvl + 64'sd8388608) >>> 24;
         gate_env = e[LEVEL_W-1:0];
         open = !(e < longint'(gate_thr));
      end
      for (i = 0; i < NUM_CH; i++) begin
         v = longint'($signed(f[i]));
         if (!open && gate_proc_mask[i]) begin
            v = (v * longint'(gate_gain) + 64'sd8388608) >>> 24;
            if (v > 64'sd8388607) v = 64'sd8388607;
            if (v < -64'sd8388608) v = -64'sd8388608;
         end
         r.ch[i] = v[SB-1:0];
      end
      r.open = open;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Request driver: presents queued frames, idles at random, and records the
   // predicted result the moment a request is accepted. Valid is only lowered
   // once the current frame has gone through.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            gated_frames_due.push_back(gated_frame(bus_frame));
         end
         if (!req_valid || req_ready) begin
            if (frames_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               bus_frame <= frames_to_send.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Result monitor: compares every accepted result with the oldest prediction
   // and drives rsp_ready. Twice during the run it holds off for a long stretch
   // so the block backs up and stalls the request side.
   // ---------------------------------------------------------------------------
   int unsigned n_results = 0;
   int unsigned hold_left = 0;

   always @(posedge clock) begin : monitor
      gate_result_t want;
      logic         took;
      int           i;
      took = rsp_valid && rsp_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (took) begin
            n_results = n_results + 1;
            if (gated_frames_due.size() == 0) begin
               $error("result with no request outstanding");
               n_fail++;
            end else begin
               want = gated_frames_due.pop_front();
               for (i = 0; i < NUM_CH; i++) begin
                  if (rsp_frame[i] !== want.ch[i]) begin
                     $error("out_%0d: expected %0d, got %0d", i,
                            $signed(want.ch[i]), $signed(rsp_frame[i]));
                     n_fail++;
                  end
               end
               if (rsp_gate_open !== want.open) begin
                  $error("gate_open: expected %0d, got %0d", want.open, rsp_gate_open);
                  n_fail++;
               end
            end
         end
         if (hold_left != 0) begin
            hold_left = hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (took && (n_results == 300 || n_results == 900)) begin
            hold_left = HOLD_CYCLES;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Watchdog: a run that stops moving ends as a failure.
   int unsigned quiet_cycles = 0;

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == QUIET_LIMIT) begin
            $display("FAIL audio_noise_gate");
            $finish;
         end
      end
   end

   // APB write: setup then access cycle; the shadow copy keeps only the
   // register's own bits, and unknown indexes change nothing.
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_MONITOR_MASK: gate_mon_mask  = value[MASK_W-1:0];
         REG_PROCESS_MASK: gate_proc_mask = value[MASK_W-1:0];
         REG_ATTACK_COEF:  gate_attack    = value[COEF_W-1:0];
         REG_RELEASE_COEF: gate_rel       = value[COEF_W-1:0];
         REG_THRESHOLD_DB: gate_thr       = value[LEVEL_W-1:0];
         REG_CLOSED_GAIN:  gate_gain      = value[GAIN_W-1:0];
         default: ;
      endcase
   endtask

   // Full gate setting; junk above each register's width must be dropped.
   task automatic gate_setting(input logic [MASK_W-1:0] mon, input logic [MASK_W-1:0] proc,
                               input logic [COEF_W-1:0] att, input logic [COEF_W-1:0] rel,
                               input logic [LEVEL_W-1:0] thr, input logic [GAIN_W-1:0] gain);
      csr_write(REG_MONITOR_MASK, (32'($urandom) << MASK_W) | 32'(mon));
      csr_write(REG_PROCESS_MASK, (32'($urandom) << MASK_W) | 32'(proc));
      csr_write(REG_ATTACK_COEF,  (32'($urandom) << COEF_W) | 32'(att));
      csr_write(REG_RELEASE_COEF, (32'($urandom) << COEF_W) | 32'(rel));
      csr_write(REG_THRESHOLD_DB, (32'($urandom) << LEVEL_W) | 32'(thr));
      csr_write(REG_CLOSED_GAIN,  (32'($urandom) << GAIN_W) | 32'(gain));
   endtask

   // Coefficients: half fully random, half close to one (slow, audio-like).
   function automatic logic [COEF_W-1:0] rand_coef();
      if ($urandom_range(1) == 1) begin
         return COEF_W'($urandom);
      end
      return 24'hffffff - COEF_W'($urandom_range(65535));
   endfunction

   function automatic logic [LEVEL_W-1:0] rand_thr();
      return LEVEL_W'($urandom_range(30000)) - LEVEL_W'(25000);   // about -98 to +20 dB
   endfunction

   // Wait for the block to go idle: nothing queued, nothing in flight.
   task automatic wait_drained();
      @(negedge clock);
      while (frames_to_send.size() != 0 || req_valid || gated_frames_due.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Random frames in bursts of equal loudness, so the envelope climbs and decays
   // across the threshold; a few silent, full-scale and cancelling frames mixed in.
   task automatic random_phase(input int n, input int idle, input int stall);
      frame_t               f;
      logic signed [SB-1:0] smp;
      int                   left;
      int                   shift;
      int                   kind;
      int                   k;
      @(negedge clock);
      send_idle_pct = idle;
      stall_pct     = stall;
      left  = 0;
      shift = 0;
      repeat (n) begin
         if (left == 0) begin
            left  = $urandom_range(24, 1);
            shift = $urandom_range(SB - 1, 0);
         end
         left--;
         kind = $urandom_range(99);
         for (k = 0; k < NUM_CH; k++) begin
            smp = SB'($urandom);
            if (kind < 4) begin
               f[k] = '0;
            end else if (kind < 9) begin
               f[k] = ($urandom_range(1) == 1) ? 24'h7fffff : 24'h800000;
            end else if (kind < 13) begin
               // pairwise cancellation: the monitored sum is often exactly zero
               smp = (smp >>> 1) >>> shift;
               f[k] = (k % 2 == 0) ? smp : -$signed(f[k-1]);
            end else begin
               f[k] = smp >>> shift;
            end
         end
         frames_to_send.push_back(f);
      end
      wait_drained();
   endtask

   initial begin : stimulus
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: gate closes below -60 dB with zero gain, no smoothing.
      @(negedge clock);
      frames_to_send.push_back('0);                                  // zero sum, -180 dB
      frames_to_send.push_back({NUM_CH{24'h7fffff}});                // loudest positive
      frames_to_send.push_back({NUM_CH{24'h800000}});                // loudest negative
      frames_to_send.push_back(frame_t'(1));                         // single LSB
      frames_to_send.push_back({4{24'h800001, 24'h7fffff}});         // cancels to zero
      frames_to_send.push_back({4{24'h800000, 24'h7fffff}});         // sums to -4
      frames_to_send.push_back({NUM_CH{24'h000800}});                // just above threshold
      wait_drained();

      // Frozen envelope, gate forced shut, gain near two: products saturate.
      gate_setting(8'h01, 8'haa, 24'hffffff, 24'hffffff, 17'h0ffff, 25'h1ffffff);
      @(negedge clock);
      frames_to_send.push_back({NUM_CH{24'h7fffff}});
      frames_to_send.push_back({NUM_CH{24'h800000}});
      frames_to_send.push_back({NUM_CH{24'h400000}});
      frames_to_send.push_back({NUM_CH{24'h000001}});
      wait_drained();

      // Empty monitor mask: frames pass untouched. Also a write to an unused slot.
      gate_setting(8'h00, 8'hff, 24'h000000, 24'hffffff, 17'h0ffff, 25'h0000000);
      csr_write(REG_SPARE, 32'($urandom));
      @(negedge clock);
      frames_to_send.push_back({NUM_CH{24'h7fffff}});
      frames_to_send.push_back({NUM_CH{24'h800000}});
      frames_to_send.push_back(frame_t'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                         $urandom}));
      wait_drained();

      // Lowest threshold: gate always open.
      gate_setting(8'hff, 8'h55, 24'h000000, 24'h000000, 17'h10000, 25'h1000000);
      @(negedge clock);
      frames_to_send.push_back('0);
      frames_to_send.push_back({24'hffffff, {7{24'h000000}}});
      wait_drained();

      // Half gain at 0 dB threshold: rounding of odd samples, both signs.
      gate_setting(8'hff, 8'hff, 24'h800000, 24'h800000, 17'h00000, 25'h0800000);
      @(negedge clock);
      frames_to_send.push_back({2{24'hfffffd, 24'h000003, 24'hffffff, 24'h000001}});
      frames_to_send.push_back({NUM_CH{24'h7fffff}});
      frames_to_send.push_back({2{24'hfffffd, 24'h000003, 24'hffffff, 24'h000001}});
      frames_to_send.push_back({4{24'h800000, 24'h7fffff}});
      wait_drained();

      // Random traffic under a series of settings and idle patterns.
      gate_setting(8'hff, 8'hff, rand_coef(), rand_coef(), 17'h1d800,
                   GAIN_W'($urandom_range(16777216)));
      random_phase(200, 0, 0);
      gate_setting(8'($urandom_range(255, 1)), 8'($urandom), 24'hffffff, 24'h000000,
                   rand_thr(), 25'h1000000);
      random_phase(250, 48, 0);
      gate_setting(8'($urandom_range(255, 1)), 8'($urandom), 24'h000000, 24'hffffff,
                   rand_thr(), 25'h0000000);
      random_phase(250, 0, 48);
      gate_setting(8'h00, 8'($urandom), rand_coef(), rand_coef(), rand_thr(),
                   GAIN_W'($urandom_range(16777216)));
      random_phase(60, 28, 28);
      gate_setting(8'($urandom_range(255, 1)), 8'($urandom), rand_coef(), rand_coef(),
                   rand_thr(), GAIN_W'($urandom_range(16777216)));
      random_phase(200, 28, 28);
      gate_setting(8'($urandom_range(255, 1)), 8'($urandom), rand_coef(), rand_coef(),
                   rand_thr(), GAIN_W'($urandom_range(16777216)));
      random_phase(200, 0, 0);

      if (n_fail == 0) begin
         $display("PASS audio_noise_gate");
      end else begin
         $display("FAIL audio_noise_gate");
      end
      $finish;
   end

endmodule

>>> audio_noise_gate.f
hdl/ang_pkg.sv
hdl/audio_noise_gate.sv
hdl/ang_checker.sv
bench/testbench.sv
